// ----- rtl/wcd_pkg.sv -----
// ----------------------------------------------------------------------------
// wcd_pkg
// Shared constants, register indexes and helpers for the Wilson-Cowan
// drift unit.
// ----------------------------------------------------------------------------
package wcd_pkg;

  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXCIT_DRIVE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXCIT_SIGMOID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXCIT_RELAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INHIB_DRIVE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INHIB_SIGMOID = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INHIB_RELAX   = 3'd5;

  // Logistic approximation constants
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam logic [15:0] EXP_LIN_Q16  = 16'd43017;
  localparam logic [13:0] EXP_QUAD_Q16 = 14'd10249;
  localparam logic [17:0] ONE_Q16      = 18'd65536;

  // Reciprocal unit: one quotient bit per stage
  localparam int unsigned RECIP_STAGES = 17;
  // Register stages through one lane, first register to drift register
  localparam int unsigned LANE_LAT = 9 + RECIP_STAGES + 3;

  typedef logic [REG_W-1:0] cfg_reg_t;

  // Signed Q8.8 slot k of a packed coefficient register
  function automatic logic signed [15:0] slot(input cfg_reg_t r, input logic [1:0] k);
    logic [15:0] v;
    case (k)
      2'd0:    v = r[15:0];
      2'd1:    v = r[31:16];
      2'd2:    v = r[47:32];
      2'd3:    v = r[63:48];
      default: v = r[15:0];
    endcase
    return $signed(v);
  endfunction

endpackage

// ----- rtl/wcd_recip.sv -----
// ----------------------------------------------------------------------------
// wcd_recip
// Pipelined restoring divider giving floor(2^32 / den) for den in
// [65536, 131072], one quotient bit per stage.
// ----------------------------------------------------------------------------
module wcd_recip (
  input  logic        clk,
  input  logic        en,
  input  logic [17:0] den,
  output logic [16:0] quo
);

  localparam int unsigned NS = wcd_pkg::RECIP_STAGES;

  logic [16:0] rem_r [NS];
  logic [17:0] den_r [NS];
  logic [16:0] quo_r [NS];

  logic [16:0] rem_in  [NS];
  logic [17:0] den_in  [NS];
  logic [16:0] quo_in  [NS];
  logic [16:0] rem_nxt [NS];
  logic [16:0] quo_nxt [NS];

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      logic [17:0] r2;
      if (j == 0) begin
        // The numerator's top bits, 2^32 >> 17, sit below any divisor.
        rem_in[j] = 17'h08000;
        den_in[j] = den;
        quo_in[j] = '0;
      end else begin
        rem_in[j] = rem_r[j-1];
        den_in[j] = den_r[j-1];
        quo_in[j] = quo_r[j-1];
      end
      r2 = {rem_in[j], 1'b0};
      if (r2 >= den_in[j]) begin
        rem_nxt[j] = 17'(r2 - den_in[j]);
        quo_nxt[j] = {quo_in[j][15:0], 1'b1};
      end else begin
        rem_nxt[j] = r2[16:0];
        quo_nxt[j] = {quo_in[j][15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_in[j];
        quo_r[j] <= quo_nxt[j];
      end
    end
  end

  assign quo = quo_r[NS-1];

endmodule

// ----- rtl/wcd_lane.sv -----
// ----------------------------------------------------------------------------
// wcd_lane
// One population's drift pipeline: drive, logistic sigmoid and relaxation.
// ----------------------------------------------------------------------------
module wcd_lane (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [15:0]     xe,
  input  logic signed [15:0]     xi,
  input  logic signed [15:0]     own,
  input  logic signed [15:0]     c0,
  input  logic signed [15:0]     c1,
  input  wcd_pkg::cfg_reg_t      drv,
  input  wcd_pkg::cfg_reg_t      sig,
  input  wcd_pkg::cfg_reg_t      rel,
  output logic signed [31:0]     drift
);

  localparam int unsigned NSIDE = 27;
  localparam int unsigned IDX_FLAGS = 3;
  localparam int unsigned IDX_A = 26;
  localparam int unsigned IDX_B = 27;

  typedef struct packed {
    logic signed [32:0] m;
    logic signed [15:0] own;
    logic               neg;
    logic               sat;
  } side_t;

  logic signed [15:0] alpha, w1, w2, bias, theta, cc, aa, bb, kk, rr, rtau;
  assign alpha = wcd_pkg::slot(drv, 2'd0);
  assign w1    = wcd_pkg::slot(drv, 2'd1);
  assign w2    = wcd_pkg::slot(drv, 2'd2);
  assign bias  = wcd_pkg::slot(drv, 2'd3);
  assign theta = wcd_pkg::slot(sig, 2'd0);
  assign cc    = wcd_pkg::slot(sig, 2'd1);
  assign aa    = wcd_pkg::slot(sig, 2'd2);
  assign bb    = wcd_pkg::slot(sig, 2'd3);
  assign kk    = wcd_pkg::slot(rel, 2'd0);
  assign rr    = wcd_pkg::slot(rel, 2'd1);
  assign rtau  = wcd_pkg::slot(rel, 2'd2);

  side_t side_r [NSIDE];

  logic signed [34:0] u_r;
  logic signed [42:0] h_r;
  logic signed [51:0] t_r;
  logic [19:0]        tl_r;
  logic [20:0]        y_r;
  logic [4:0]         n6_r, n7_r, n8_r;
  logic [15:0]        f_r, f7_r;
  logic [13:0]        q1_r;
  logic [15:0]        q2_r;
  logic [17:0]        den_r;
  logic signed [25:0] s_r;
  logic signed [43:0] v_r;
  logic signed [31:0] drift_r;
  logic [16:0]        quo;

  // Combinational terms per stage
  logic signed [17:0] s4;
  logic signed [34:0] u_c;
  logic signed [32:0] m_c;
  logic signed [50:0] p2;
  logic signed [43:0] hb;
  logic signed [59:0] p3;
  logic [51:0]        tabs;
  logic [36:0]        p5;
  logic [29:0]        p6;
  logic [15:0]        inner;
  logic [31:0]        p7;
  logic [16:0]        pexp;
  logic [16:0]        eexp;
  logic [16:0]        lval;
  logic signed [17:0] ls;
  logic signed [33:0] pa;
  logic signed [58:0] pb;
  logic signed [43:0] v_c;
  logic signed [59:0] pc;
  logic signed [51:0] d_c;
  logic signed [31:0] d_sat;

  always_comb begin
    s4    = bias - theta + c0 + c1;
    u_c   = w1 * xe - w2 * xi + (35'(s4) <<< 8);
    m_c   = (33'(kk) <<< 8) - rr * own;
    p2    = alpha * u_r;
    hb    = 44'(h_r) - (44'(bb) <<< 8);
    p3    = aa * hb;
    tabs  = t_r[51] ? 52'(-t_r) : 52'(t_r);
    p5    = tl_r * wcd_pkg::LOG2E_Q16;
    p6    = f_r * wcd_pkg::EXP_QUAD_Q16;
    inner = wcd_pkg::EXP_LIN_Q16 - 16'(q1_r);
    p7    = f7_r * inner;
    pexp  = 17'(wcd_pkg::ONE_Q16 - 18'(q2_r));
    eexp  = pexp >> n8_r;
    // Saturated logistic is exactly one; negative arguments mirror about one half.
    lval  = side_r[IDX_A-1].sat ? wcd_pkg::ONE_Q16[16:0] : quo;
    ls    = side_r[IDX_A-1].neg ? $signed(wcd_pkg::ONE_Q16 - 18'(lval))
                                : $signed(18'(lval));
    pa    = cc * ls;
    pb    = side_r[IDX_B-1].m * s_r;
    v_c   = -(44'(side_r[IDX_B-1].own) <<< 8) + 44'(pb >>> 16);
    pc    = v_r * rtau;
    d_c   = 52'(pc >>> 8);
    if (d_c > 52'sh7FFFFFFF) begin
      d_sat = 32'sh7FFFFFFF;
    end else if (d_c < -52'sh80000000) begin
      d_sat = -32'sh80000000;
    end else begin
      d_sat = d_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r   <= u_c;
      h_r   <= 43'(p2 >>> 8);
      t_r   <= 52'(p3 >>> 8);
      tl_r  <= tabs[19:0];
      y_r   <= p5[36:16];
      n6_r  <= y_r[20:16];
      f_r   <= y_r[15:0];
      q1_r  <= p6[29:16];
      f7_r  <= f_r;
      n7_r  <= n6_r;
      q2_r  <= p7[31:16];
      n8_r  <= n7_r;
      den_r <= wcd_pkg::ONE_Q16 + 18'(eexp);
      s_r   <= 26'(pa >>> 8);
      v_r   <= v_c;
      drift_r <= d_sat;

      side_r[0] <= '{m: m_c, own: own, neg: 1'b0, sat: 1'b0};
      for (int k = 1; k < NSIDE; k++) begin
        if (k == IDX_FLAGS) begin
          side_r[k] <= '{m: side_r[k-1].m, own: side_r[k-1].own, neg: t_r[51],
                         sat: (tabs[51:20] != '0)};
        end else begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  wcd_recip u_recip (
    .clk (clk),
    .en  (en),
    .den (den_r),
    .quo (quo)
  );

  assign drift = drift_r;

endmodule

// ----- rtl/wilson_cowan_drift_unit.sv -----
// ----------------------------------------------------------------------------
// wilson_cowan_drift_unit
// Wilson-Cowan neural-mass drift for an excitatory and an inhibitory lane.
// ----------------------------------------------------------------------------
// One beat in gives one beat out, and a new beat is taken every cycle unless
// the pipeline stalls. Two identical lanes, one per population, each run a
// 29-stage pipeline whose length is set mainly by the 17-stage reciprocal
// divider of the logistic; the output register merges both drifts with the noise
// gain. The whole pipeline stalls only while a result waits at the output and
// out_tready is low. Coefficients are read live, so write them only while
// no beat is in flight.
module wilson_cowan_drift_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // excit_activity, inhib_activity, coupling_first, coupling_second
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drift_excit, drift_inhib, noise_gain
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  localparam int unsigned LAT = wcd_pkg::LANE_LAT;

  wcd_pkg::cfg_reg_t cfg_r [wcd_pkg::NUM_REGS];
  logic [LAT-1:0]    vld_r;
  logic              out_tvalid_r;
  logic [79:0]       out_tdata_r;
  logic              adv;
  logic signed [31:0] drift_e, drift_i;
  logic signed [15:0] xe, xi, c0, c1;

  assign adv = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  assign xe = $signed(in_tdata[15:0]);
  assign xi = $signed(in_tdata[31:16]);
  assign c0 = $signed(in_tdata[47:32]);
  assign c1 = $signed(in_tdata[63:48]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wcd_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we && (32'(cfg_idx) < wcd_pkg::NUM_REGS)) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  wcd_lane u_lane_e (
    .clk   (clk),
    .en    (adv),
    .xe    (xe),
    .xi    (xi),
    .own   (xe),
    .c0    (c0),
    .c1    (c1),
    .drv   (cfg_r[wcd_pkg::REG_EXCIT_DRIVE]),
    .sig   (cfg_r[wcd_pkg::REG_EXCIT_SIGMOID]),
    .rel   (cfg_r[wcd_pkg::REG_EXCIT_RELAX]),
    .drift (drift_e)
  );

  wcd_lane u_lane_i (
    .clk   (clk),
    .en    (adv),
    .xe    (xe),
    .xi    (xi),
    .own   (xi),
    .c0    (c0),
    .c1    (c1),
    .drv   (cfg_r[wcd_pkg::REG_INHIB_DRIVE]),
    .sig   (cfg_r[wcd_pkg::REG_INHIB_SIGMOID]),
    .rel   (cfg_r[wcd_pkg::REG_INHIB_RELAX]),
    .drift (drift_i)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      vld_r        <= {vld_r[LAT-2:0], in_tvalid};
      out_tvalid_r <= vld_r[LAT-1];
    end
  end

  // Merge stage: both lane drifts plus the pass-through noise gain.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {cfg_r[wcd_pkg::REG_EXCIT_RELAX][63:48], drift_i, drift_e};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- tb/wilson_cowan_drift_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wilson-Cowan drift unit testbench
// Streams activity beats through the drift unit under a series of coefficient
// settings. Each beat is predicted in Q16.16 by a scoreboard and checked field
// by field in order. Both sides idle at random, and one long receiver hold-off
// fills the pipeline.
// ----------------------------------------------------------------------------
module wilson_cowan_drift_unit_test;

  typedef struct {
    logic [31:0] drift_excit;
    logic [31:0] drift_inhib;
    logic [15:0] noise_gain;
  } drift_beat_t;

  class drift_scoreboard;
    logic [63:0]  coeffs [wcd_pkg::NUM_REGS];
    drift_beat_t  awaited [$];
    int           mismatches;

    function new();
      foreach (coeffs[i]) coeffs[i] = '0;
      mismatches = 0;
    endfunction

    function void load_reg(input logic [2:0] idx, input logic [63:0] val);
      if (idx < wcd_pkg::NUM_REGS) coeffs[idx] = val;
    endfunction

    function automatic longint coeff(input logic [63:0] r, input int k);
      logic signed [15:0] v;
      v = r[16*k +: 16];
      return longint'(v);
    endfunction

    // Piecewise exponential followed by a reciprocal, all in Q16.16.
    function automatic longint logistic_q16(input longint t);
      longint unsigned mag, y, n, f, inner, p, e;
      longint lv;
      mag = (t < 0) ? longint'(-t) : longint'(t);
      if (mag >= 64'd1048576) begin
        lv = 65536;
      end else begin
        y = (mag * 64'd94548) >> 16;
        n = y >> 16;
        f = y & 64'hFFFF;
        inner = 64'd43017 - ((64'd10249 * f) >> 16);
        p = 64'd65536 - ((f * inner) >> 16);
        e = p >> n;
        lv = longint'((64'd1 << 32) / (64'd65536 + e));
      end
      return (t < 0) ? 65536 - lv : lv;
    endfunction

    function automatic logic [31:0] lane_drift(input logic [63:0] drv, sig, rel,
                                               input longint xe, xi, own, c0, c1);
      longint u, h, t, s, m, v, d;
      u = coeff(drv, 1) * xe - coeff(drv, 2) * xi
          + 256 * (coeff(drv, 3) - coeff(sig, 0) + c0 + c1);
      h = (coeff(drv, 0) * u) >>> 8;
      t = (coeff(sig, 2) * (h - 256 * coeff(sig, 3))) >>> 8;
      s = (coeff(sig, 1) * logistic_q16(t)) >>> 8;
      m = 256 * coeff(rel, 0) - coeff(rel, 1) * own;
      v = -256 * own + ((m * s) >>> 16);
      d = (v * coeff(rel, 2)) >>> 8;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      return d[31:0];
    endfunction

    function void note_input(input logic [63:0] beat);
      drift_beat_t exp_beat;
      longint xe, xi, c0, c1;
      xe = coeff(beat, 0);
      xi = coeff(beat, 1);
      c0 = coeff(beat, 2);
      c1 = coeff(beat, 3);
      exp_beat.drift_excit = lane_drift(coeffs[wcd_pkg::REG_EXCIT_DRIVE],
                                        coeffs[wcd_pkg::REG_EXCIT_SIGMOID],
                                        coeffs[wcd_pkg::REG_EXCIT_RELAX],
                                        xe, xi, xe, c0, c1);
      exp_beat.drift_inhib = lane_drift(coeffs[wcd_pkg::REG_INHIB_DRIVE],
                                        coeffs[wcd_pkg::REG_INHIB_SIGMOID],
                                        coeffs[wcd_pkg::REG_INHIB_RELAX],
                                        xe, xi, xi, c0, c1);
      exp_beat.noise_gain = coeffs[wcd_pkg::REG_EXCIT_RELAX][63:48];
      awaited.push_back(exp_beat);
    endfunction

    function void check_result(input logic [79:0] beat);
      drift_beat_t exp_beat;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output beat %h", beat);
        return;
      end
      exp_beat = awaited.pop_front();
      if (beat[31:0] !== exp_beat.drift_excit || beat[63:32] !== exp_beat.drift_inhib ||
          beat[79:64] !== exp_beat.noise_gain) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: drift_excit %h/%h drift_inhib %h/%h noise_gain %h/%h (exp/act)",
                   exp_beat.drift_excit, beat[31:0], exp_beat.drift_inhib, beat[63:32],
                   exp_beat.noise_gain, beat[79:64]);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [63:0] cfg_wdata = '0;

  drift_scoreboard sb = new();
  bit  idle_enable = 1'b0;
  int  hold_off = 0;
  int  quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  always #6 clk = ~clk;

  wilson_cowan_drift_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Receiver: the hold-off is counted down here, one cycle at a time.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_enable && $urandom_range(99) < 30);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so the next beat can follow directly.
  task automatic send_beat(input logic [63:0] beat);
    while (idle_enable && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    do @(posedge clk); while (!in_tready);
    sb.note_input(beat);
    @(negedge clk);
  endtask

  // Drains the pipeline, then loads all six registers and one unknown index.
  task automatic load_coeffs(input logic [63:0] vals [wcd_pkg::NUM_REGS]);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < wcd_pkg::NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= i[2:0];
      cfg_wdata <= vals[i];
      sb.load_reg(i[2:0], vals[i]);
      @(negedge clk);
    end
    // Writes to indexes past the last register must be ignored.
    cfg_idx   <= 3'(6 + $urandom_range(1));
    cfg_wdata <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coeff();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom);
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  function automatic logic [15:0] rand_activity();
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(512)) - 256);
    endcase
  endfunction

  initial begin
    logic [63:0] cfg_set [wcd_pkg::NUM_REGS];
    logic [15:0] edge_vals [6];
    edge_vals = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0100, 16'hFF00};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With everything at reset the time constants are zero, so drifts are zero.
    send_beat({16'h1234, 16'h8000, 16'h7FFF, 16'h0100});
    send_beat({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});

    // A plausible excitatory/inhibitory setting for the directed beats.
    cfg_set[wcd_pkg::REG_EXCIT_DRIVE]   = {16'h0080, 16'h0400, 16'h0C00, 16'h0100};
    cfg_set[wcd_pkg::REG_EXCIT_SIGMOID] = {16'h0380, 16'h0133, 16'h0100, 16'h0040};
    cfg_set[wcd_pkg::REG_EXCIT_RELAX]   = {16'h0019, 16'h0100, 16'h0100, 16'h0100};
    cfg_set[wcd_pkg::REG_INHIB_DRIVE]   = {16'h0000, 16'h0300, 16'h0F00, 16'h0100};
    cfg_set[wcd_pkg::REG_INHIB_SIGMOID] = {16'h0200, 16'h0100, 16'h0100, 16'h0080};
    cfg_set[wcd_pkg::REG_INHIB_RELAX]   = {16'h5A5A, 16'h0200, 16'h0100, 16'h0100};
    load_coeffs(cfg_set);
    foreach (edge_vals[i]) begin
      send_beat({4{edge_vals[i]}});
      send_beat({edge_vals[i], ~edge_vals[i], edge_vals[i], ~edge_vals[i]});
    end
    // Very large drives push the logistic into saturation both ways.
    send_beat({16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF});
    send_beat({16'h8000, 16'h8000, 16'h7FFF, 16'h8000});
    send_beat({16'h0000, 16'h0000, 16'h7FFF, 16'h8000});

    for (int phase = 0; phase < 13; phase++) begin
      for (int i = 0; i < wcd_pkg::NUM_REGS; i++) begin
        case (phase)
          0:       cfg_set[i] = '1;
          1:       cfg_set[i] = {4{16'h7FFF}};
          2:       cfg_set[i] = {4{16'h8000}};
          default: cfg_set[i] = {rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff()};
        endcase
      end
      load_coeffs(cfg_set);
      idle_enable = (phase % 4 != 3);
      if (phase == 5) hold_off = 300;
      for (int n = 0; n < 115; n++)
        send_beat({rand_activity(), rand_activity(), rand_activity(), rand_activity()});
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
